/* hw/rtl/lmsf_pkg.sv */
// Shared constants, codes and control types for the LMS adaptive FIR.
package lmsf_pkg;

   localparam int TAPS_DEF = 32;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0]  REG_STEP_SIZE   = 1'b0;
   localparam logic [15:0] STEP_SIZE_RESET = 16'd328;

   // Request kinds
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_ERROR  = 1'b1;

   // Sequencer to datapath control
   typedef struct packed {
      logic start;    // item taken this cycle
      logic op_err;   // item kind of the one taken
      logic hist_we;  // write new sample into history
      logic issue;    // tap read issued this cycle
      logic hist_ok;  // tap holds a real sample
   } ctl_type;

endpackage

/* hw/rtl/lms_adaptive_fir_top.sv */
// Top level of the LMS adaptive FIR filter: CSR block, sequencer and MAC datapath.
// Sample transfer: the result is valid once RUN, DRAIN and FINISH are done, later while an earlier
// result still awaits its transfer; the next item is taken only after FINISH.
// Error transfer: no result; the next item is taken once RUN and DRAIN are done.
// The pace is one tap per cycle through the single read port of each memory and one multiplier.
// Synchronous active-high reset: history empty (fill count 0), all weights zero via per-tap
// valid bits, step size 328; no clearing pass, the block takes items straight after reset.
module lms_adaptive_fir_top #(
   parameter int TAPS = lmsf_pkg::TAPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic signed [15:0]                  req_sample_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_filter_out,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lmsf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lmsf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lmsf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import lmsf_pkg::*;

   localparam int IDX_W = $clog2(TAPS);

   ctl_type          ctl;
   logic [15:0]      step_size;
   logic [IDX_W-1:0] hist_waddr;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] tap_idx;
   logic             busy;
   logic [15:0]      filt;

   // Step size register; write it only while the block is idle; the block has no check for it.
   lmsf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .step_size   (step_size)
   );

   // Sequencer: one item at a time, walks taps newest first, holds the result register
   // so a new item may be taken while a result still awaits its transfer.
   lmsf_seq #(
      .TAPS (TAPS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filter_out (rsp_filter_out),
      .ctl            (ctl),
      .hist_waddr     (hist_waddr),
      .rd_addr        (rd_addr),
      .tap_idx        (tap_idx),
      .busy           (busy),
      .filt           (filt)
   );

   // Datapath: history ring buffer and weight memory, read-multiply-accumulate for a sample,
   // read-modify-write of every weight for an error. Successive weight writes hit distinct
   // taps, and the pipeline drains before the next item, so no forwarding is needed.
   lmsf_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .hist_waddr (hist_waddr),
      .rd_addr    (rd_addr),
      .tap_idx    (tap_idx),
      .sample     (req_sample_value),
      .step_size  (step_size),
      .busy       (busy),
      .filt       (filt)
   );

endmodule

/* hw/rtl/lmsf_csr.sv */
// APB-style configuration register block (step size).
module lmsf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lmsf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lmsf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lmsf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [15:0]                         step_size
);
   import lmsf_pkg::*;

   logic [15:0] step_ff, step_in;
   logic        sel_step;

   assign sel_step = (csr_paddr[CSR_ADDR_W-1:2] == REG_STEP_SIZE);

   always_comb begin
      step_in = step_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_step) begin
         step_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_SIZE_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   assign csr_prdata = sel_step ? {{(CSR_DATA_W-16){1'b0}}, step_ff} : '0;
   assign csr_pready = 1'b1;
   assign step_size  = step_ff;

endmodule

/* hw/rtl/lmsf_mac.sv */
// History and weight memories with the shared multiply, accumulate and update pipeline.
module lmsf_mac #(
   parameter int TAPS = lmsf_pkg::TAPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lmsf_pkg::ctl_type           ctl,
   input  logic [$clog2(TAPS)-1:0]     hist_waddr,
   input  logic [$clog2(TAPS)-1:0]     rd_addr,
   input  logic [$clog2(TAPS)-1:0]     tap_idx,
   input  logic signed [15:0]          sample,
   input  logic [15:0]                 step_size,
   output logic                        busy,
   output logic [15:0]                 filt
);
   import lmsf_pkg::*;

   localparam int IDX_W = $clog2(TAPS);
   localparam int ACC_W = 49 + $clog2(TAPS);
   localparam int Y_W   = ACC_W - 28;

   // memories
   logic [15:0] hist_mem [TAPS];
   logic [31:0] wt_mem   [TAPS];
   logic [TAPS-1:0] wt_vld_ff, wt_vld_in;

   // item state
   logic               op_err_ff;
   logic signed [32:0] sx_ff;

   // stage 1: read data
   logic               s1_vld_ff, s1_hok_ff, s1_wvld_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [15:0]        hist_rd_ff;
   logic [31:0]        wt_rd_ff;

   // stage 2: product
   logic               s2_vld_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [31:0] w_s2_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic signed [15:0] h_eff;
   logic signed [31:0] w_eff;
   logic signed [32:0] mul_a;
   logic signed [48:0] d_full;
   logic signed [30:0] delta;
   logic signed [32:0] w_sum;
   logic [31:0]        w_new;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [Y_W-1:0]   y_sh;

   always_ff @(posedge clock) begin
      if (ctl.hist_we) begin
         hist_mem[hist_waddr] <= sample;
      end
      if (ctl.issue) begin
         hist_rd_ff <= hist_mem[rd_addr];
         wt_rd_ff   <= wt_mem[tap_idx];
      end
      if (s2_vld_ff && op_err_ff) begin
         wt_mem[s2_idx_ff] <= w_new;
      end
   end

   // masking of never-written entries
   assign h_eff = s1_hok_ff  ? $signed(hist_rd_ff) : 16'sd0;
   assign w_eff = s1_wvld_ff ? $signed(wt_rd_ff)   : 32'sd0;
   assign mul_a = op_err_ff ? sx_ff : {w_eff[31], w_eff};
   assign prod_in = mul_a * h_eff;

   // weight update: round half up to Q4.28, saturate to 32 bits
   assign d_full = prod_ff + 49'sd131072;
   assign delta  = d_full[48:18];
   assign w_sum  = {w_s2_ff[31], w_s2_ff} + {{2{delta[30]}}, delta};
   always_comb begin
      if (w_sum[32] != w_sum[31]) begin
         w_new = w_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         w_new = w_sum[31:0];
      end
   end

   always_comb begin
      wt_vld_in = wt_vld_ff;
      if (s2_vld_ff && op_err_ff) begin
         wt_vld_in[s2_idx_ff] = 1'b1;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.start) begin
         acc_in = '0;
      end else if (s2_vld_ff && !op_err_ff) begin
         acc_in = acc_ff + {{(ACC_W-49){prod_ff[48]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_vld_ff <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         op_err_ff <= OP_SAMPLE;
      end else begin
         wt_vld_ff <= wt_vld_in;
         s1_vld_ff <= ctl.issue;
         s2_vld_ff <= s1_vld_ff;
         if (ctl.start) begin
            op_err_ff <= ctl.op_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         sx_ff <= $signed({1'b0, step_size}) * sample;
      end
      s1_idx_ff  <= tap_idx;
      s1_hok_ff  <= ctl.hist_ok;
      s1_wvld_ff <= wt_vld_ff[tap_idx];
      s2_idx_ff  <= s1_idx_ff;
      prod_ff    <= prod_in;
      w_s2_ff    <= w_eff;
      acc_ff     <= acc_in;
   end

   // output: round half up from Q5.43 to Q1.15, saturate
   assign acc_rnd = acc_ff + ACC_W'(28'h800_0000);
   assign y_sh    = acc_rnd[ACC_W-1:28];
   always_comb begin
      if (y_sh[Y_W-1:15] != {(Y_W-15){y_sh[Y_W-1]}}) begin
         filt = y_sh[Y_W-1] ? 16'h8000 : 16'h7FFF;
      end else begin
         filt = y_sh[15:0];
      end
   end

   assign busy = s1_vld_ff | s2_vld_ff;

endmodule

/* hw/rtl/lmsf_seq.sv */
// Item sequencer: handshakes, circular history pointer, tap walk and result register.
module lmsf_seq #(
   parameter int TAPS = lmsf_pkg::TAPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [15:0]          rsp_filter_out,
   output lmsf_pkg::ctl_type           ctl,
   output logic [$clog2(TAPS)-1:0]     hist_waddr,
   output logic [$clog2(TAPS)-1:0]     rd_addr,
   output logic [$clog2(TAPS)-1:0]     tap_idx,
   input  logic                        busy,
   input  logic [15:0]                 filt
);
   import lmsf_pkg::*;

   localparam int IDX_W = $clog2(TAPS);
   localparam int CNT_W = $clog2(TAPS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TAPS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in, head_nxt;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             op_ff, op_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [15:0]      rsp_data_ff, rsp_data_in;
   logic             take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign head_nxt  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      addr_in     = addr_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      ctl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               ctl.start  = 1'b1;
               ctl.op_err = req_type;
               op_in      = req_type;
               idx_in     = '0;
               state_in   = ST_RUN;
               if (req_type == OP_SAMPLE) begin
                  ctl.hist_we = 1'b1;
                  head_in     = head_nxt;
                  addr_in     = head_nxt;
                  if (fill_ff != FULL_CNT) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  addr_in = head_ff;
               end
            end
         end
         ST_RUN: begin
            ctl.issue   = 1'b1;
            ctl.op_err  = op_ff;
            ctl.hist_ok = (CNT_W'(idx_ff) < fill_ff);
            addr_in     = (addr_ff == '0) ? LAST_IDX : addr_ff - 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ctl.op_err = op_ff;
            if (!busy) begin
               state_in = (op_ff == OP_ERROR) ? ST_IDLE : ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = filt;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         fill_ff    <= '0;
         addr_ff    <= '0;
         idx_ff     <= '0;
         op_ff      <= OP_SAMPLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         addr_ff    <= addr_in;
         idx_ff     <= idx_in;
         op_ff      <= op_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign hist_waddr     = head_nxt;
   assign rd_addr        = addr_ff;
   assign tap_idx        = idx_ff;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_filter_out = rsp_data_ff;

endmodule

/* tb/sv/lms_adaptive_fir_top_tb.sv */
// Self-checking testbench for the LMS adaptive FIR top level: directed table, then random phases.
`timescale 1ns / 100ps

module lms_adaptive_fir_top_tb;
   import lmsf_pkg::*;

   localparam int TAPS = TAPS_DEF;
   // quiet time after the last result: covers an error update still in flight
   localparam int SETTLE = TAPS + 8;
   // watchdog limit, well above the slowest legal run
   localparam int LIMIT = 1_000_000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 112;

   // register byte addresses: step size, and an index with no register behind it
   localparam logic [CSR_ADDR_W-1:0] ADDR_STEP  = {REG_STEP_SIZE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = {~REG_STEP_SIZE, 2'b00};

   // saturation bounds: Q4.28 weights, Q1.15 output
   localparam longint W_MAX = (longint'(1) << 31) - 1;
   localparam longint W_MIN = -(longint'(1) << 31);
   localparam longint Y_MAX = 32767;
   localparam longint Y_MIN = -32768;

   typedef enum logic [0:0] {ROW_ITEM, ROW_WRITE} row_kind_type;

   // one row of the directed plan; want is only used where typed is set
   typedef struct packed {
      row_kind_type          kind;
      logic                  op;
      logic signed [15:0]    x;
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0]           data;
      int                    rpt;
      bit                    typed;
      logic signed [15:0]    want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = OP_SAMPLE;
   logic signed [15:0]    req_sample_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [15:0]    rsp_filter_out;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state: delay line (newest at 0), Q4.28 weights, step size
   logic signed [15:0] delay_line [TAPS];
   logic signed [31:0] coeff [TAPS];
   logic [15:0]        mu = STEP_SIZE_RESET;

   logic signed [15:0] filter_out_q [$];
   int                 mismatches = 0;
   int                 cycle_count = 0;
   int                 ready_hold = 0;
   logic               quiet = 1'b0;   // no idling on either side while set

   // Directed plan. Typed expectations only where they are obvious: the first samples after
   // reset see all-zero weights, so the output must be zero.
   row_type plan [17] = '{
      // error with an empty history: no weight moves
      '{ROW_ITEM,  OP_ERROR,  16'sh7FFF, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'sh7FFF, ADDR_STEP,  32'h0,         1,  1'b1, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'sh8000, ADDR_STEP,  32'h0,         1,  1'b1, 16'sh0},
      // partly filled history at the reset step size
      '{ROW_ITEM,  OP_ERROR,  16'sh8000, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'sh0000, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      // write to an index with no register: step must read back unchanged
      '{ROW_WRITE, OP_SAMPLE, 16'sh0000, ADDR_SPARE, 32'hFFFF_FFFF, 1,  1'b0, 16'sh0},
      // largest step, upper data bits dropped
      '{ROW_WRITE, OP_SAMPLE, 16'sh0000, ADDR_STEP,  32'hFFFF_FFFF, 1,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'sh8000, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      // repeated full-scale errors drive weights into both saturation rails
      '{ROW_ITEM,  OP_ERROR,  16'sh8000, ADDR_STEP,  32'h0,         10, 1'b0, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'sh8000, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'sh7FFF, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      // zero step: weights frozen
      '{ROW_WRITE, OP_SAMPLE, 16'sh0000, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_ERROR,  16'sh7FFF, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'sh0001, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0},
      // smallest non-zero step: rounding of tiny deltas
      '{ROW_WRITE, OP_SAMPLE, 16'sh0000, ADDR_STEP,  32'h1,         1,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_ERROR,  16'shFFFF, ADDR_STEP,  32'h0,         2,  1'b0, 16'sh0},
      '{ROW_ITEM,  OP_SAMPLE, 16'shFFFF, ADDR_STEP,  32'h0,         1,  1'b0, 16'sh0}
   };

   lms_adaptive_fir_top #(.TAPS(TAPS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filter_out   (rsp_filter_out),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < TAPS; i++) begin
         delay_line[i] = '0;
         coeff[i]      = '0;
      end
   end

   // Apply one transfer to the predicted state. Returns 1 with the output for a sample,
   // 0 for an error (weights adapted, nothing returned).
   function automatic bit filter_and_adapt(input logic op, input logic signed [15:0] x,
                                           output logic signed [15:0] y);
      longint acc;
      longint prod;
      longint delta;
      longint w;
      longint xs;
      longint step;
      int     i;
      y    = '0;
      xs   = x;
      step = mu;
      if (op == OP_SAMPLE) begin
         for (i = TAPS - 1; i > 0; i--)
            delay_line[i] = delay_line[i-1];
         delay_line[0] = x;
         acc = 0;
         for (i = 0; i < TAPS; i++)
            acc += longint'(delay_line[i]) * longint'(coeff[i]);
         // round half up from Q5.43 to Q1.15, floor via arithmetic shift
         acc = (acc + (longint'(1) << 27)) >>> 28;
         if (acc > Y_MAX) acc = Y_MAX;
         if (acc < Y_MIN) acc = Y_MIN;
         y = acc[15:0];
         return 1'b1;
      end
      for (i = 0; i < TAPS; i++) begin
         prod  = step * xs * longint'(delay_line[i]);
         delta = (prod + (longint'(1) << 17)) >>> 18;
         w     = longint'(coeff[i]) + delta;
         if (w > W_MAX) w = W_MAX;
         if (w < W_MIN) w = W_MIN;
         coeff[i] = w[31:0];
      end
      return 1'b0;
   endfunction

   // mostly short gaps, the odd long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // full-scale extremes, small values around zero, or anything
   function automatic logic signed [15:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return 16'($urandom_range(0, 31)) - 16'sd16;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // One request transfer. Returns at the accepting edge with valid still high, so the
   // caller must follow at once with another transfer or with drain().
   task automatic send_item(input logic op, input logic signed [15:0] x, input bit typed,
                            input logic signed [15:0] want);
      int                 gap;
      logic signed [15:0] y;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= op;
      req_sample_value <= x;
      do @(posedge clock); while (!req_ready);
      if (filter_and_adapt(op, x, y))
         filter_out_q.push_back(typed ? want : y);
   endtask

   // stop sending, wait for every result, then let any error update finish
   task automatic drain();
      req_valid <= 1'b0;
      while (filter_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[CSR_ADDR_W-1:2] == REG_STEP_SIZE)
         mu = data[15:0];
      @(posedge clock);
   endtask

   // read the step size back and compare with the predicted one
   task automatic csr_check();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_STEP;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== mu) begin
         $display("%0t: step_size readback mismatch, expected %0d, got %0d",
                  $time, mu, csr_prdata[15:0]);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: check each transfer against the oldest expectation, and throttle ready.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filter_out_q.size() == 0) begin
            $display("%0t: filter_out %0d with nothing expected", $time, rsp_filter_out);
            mismatches++;
         end else begin
            want = filter_out_q.pop_front();
            if (rsp_filter_out !== want) begin
               $display("%0t: filter_out mismatch, expected %0d, got %0d",
                        $time, want, rsp_filter_out);
               mismatches++;
            end
         end
      end
      if (quiet) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               rsp_ready  <= 1'b0;
               ready_hold <= $urandom_range(20, 60);
            end
            1, 2, 3, 4, 5, 6, 7: begin
               rsp_ready  <= 1'b0;
               ready_hold <= $urandom_range(0, 3);
            end
            default: begin
               rsp_ready  <= 1'b1;
               ready_hold <= $urandom_range(0, 20);
            end
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [15:0] step;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the step size
      csr_check();

      foreach (plan[n]) begin
         case (plan[n].kind)
            ROW_WRITE: begin
               drain();
               csr_write(plan[n].addr, plan[n].data);
               csr_check();
            end
            default: begin
               repeat (plan[n].rpt)
                  send_item(plan[n].op, plan[n].x, plan[n].typed, plan[n].want);
            end
         endcase
      end

      // Random phases. Each starts idle (sender held until all results are back), pokes the spare
      // index, then sets a new step: moderate, largest, zero, reset value, then arbitrary and moderate by turns.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: step = 16'($urandom_range(0, 4095));
            1: step = 16'hFFFF;
            2: step = '0;
            3: step = STEP_SIZE_RESET;
            default: step = (p % 2) ? 16'($urandom_range(0, 4095))
                                    : 16'($urandom_range(0, 65535));
         endcase
         csr_write(ADDR_SPARE, $urandom);
         csr_write(ADDR_STEP, {16'($urandom), step});
         csr_check();
         quiet <= (p == 2 || p == 5);
         repeat (PHASE_ITEMS)
            send_item(($urandom_range(0, 9) < 6) ? OP_SAMPLE : OP_ERROR, pick_value(),
                      1'b0, '0);
      end

      drain();
      if (mismatches == 0 && filter_out_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
